@@ design/chm_pkg.sv @@
// shared types and constants of the chained hash map
// no dependencies
package chm_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int BUCKETS_DEF  = 64;
  localparam int QUEUE_DEPTH  = 2;
  localparam int KEY_W        = 120;
  localparam int KEY_LOW_W    = 64;
  localparam int KEY_HIGH_W   = 56;
  localparam int KEY_BYTES    = 15;
  localparam int LEN_W        = 4;
  localparam int VAL_W        = 64;
  localparam int CNT_W        = 7;
  localparam int CFG_W        = 7;
  localparam int MAX_BKT_W    = 12;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam logic [31:0] HASH_MUL  = 32'h5bd1e995;
  localparam int SH_K = 24;
  localparam int SH_A = 13;
  localparam int SH_B = 15;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_DEL   = 2'd2,
    OP_CLEAN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e                  op;
    logic [KEY_W-1:0]     key;
    logic [LEN_W-1:0]     len;
    logic [VAL_W-1:0]     value;
    logic [MAX_BKT_W-1:0] bucket;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] cleared;
  } res_t;

endpackage

@@ design/chained_hash_map_string_keys.sv @@
// top level of the chained hash map: front hasher, request queue, back executor,
// result queue; depends on chm_pkg, chm_fifo, chm_front and chm_back
//
// usage
//   input side is a queue: the transaction is taken when push is high and full low
//   result side is a queue: the oldest result sits on the result ports while
//   empty is low and leaves on pop with empty low
//   bucket_count is written through cfg_we_i / cfg_wdata_i while idle
// timing
//   the front takes one transaction at a time with one shared 32x32 multiplier:
//   states K1, K2 and H for each whole 4-byte word, then tail and final mix, a
//   bit-serial remainder and a hand-over state; clean skips the hash and
//   goes straight to the hand-over
//   the back reads the bucket head, compares one chain node at a time
//   and then finishes; clean sweeps the pool, one slot per cycle
//   front and back overlap through a two-deep request queue
// reset
//   every bucket is empty, the pool is free and bucket_count is 64
// stalls
//   a full result queue holds the back, the request queue then fills and
//   full stays high until pop makes room
module chained_hash_map_string_keys #(
  parameter int ENTRIES = chm_pkg::ENTRIES_DEF,
  parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     operation_i,
  input  logic [chm_pkg::KEY_LOW_W-1:0]  key_low_i,
  input  logic [chm_pkg::KEY_HIGH_W-1:0] key_high_i,
  input  logic [chm_pkg::LEN_W-1:0]      key_length_i,
  input  logic [chm_pkg::VAL_W-1:0]      value_in_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [1:0]                     status_o,
  output logic [chm_pkg::VAL_W-1:0]      value_out_o,
  output logic [chm_pkg::CNT_W-1:0]      cleared_count_o,
  input  logic                           cfg_we_i,
  input  logic [chm_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import chm_pkg::*;

  // bucket count register
  logic [CFG_W-1:0] bucket_count_q;

  // front to request queue
  logic fr_valid, fr_ready, rq_full, rq_empty, rq_pop;
  req_t fr_req, rq_req;
  logic [$bits(req_t)-1:0] rq_data;

  // back to result queue
  logic bk_push, res_full;
  res_t bk_res, out_res;
  logic [$bits(res_t)-1:0] res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  chm_front #(.BUCKETS(BUCKETS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .operation_i    (operation_i),
    .key_low_i      (key_low_i),
    .key_high_i     (key_high_i),
    .key_length_i   (key_length_i),
    .value_in_i     (value_in_i),
    .bucket_count_i (bucket_count_q),
    .req_valid_o    (fr_valid),
    .req_o          (fr_req),
    .req_ready_i    (fr_ready)
  );

  assign fr_ready = !rq_full;

  // request queue decouples hashing from the chain walk
  chm_fifo #(.WIDTH($bits(req_t)), .DEPTH(QUEUE_DEPTH)) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_req),
    .full_o  (rq_full),
    .pop_i   (rq_pop),
    .data_o  (rq_data),
    .empty_o (rq_empty)
  );

  assign rq_req = req_t'(rq_data);

  chm_back #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (!rq_empty),
    .req_i       (rq_req),
    .req_pop_o   (rq_pop),
    .res_ready_i (!res_full),
    .res_push_o  (bk_push),
    .res_o       (bk_res)
  );

  // result queue, the back only starts a transaction with room here
  chm_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .data_i  (bk_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign out_res         = res_t'(res_data);
  assign status_o        = out_res.status;
  assign value_out_o     = out_res.value;
  assign cleared_count_o = out_res.cleared;
endmodule

@@ design/chm_fifo.sv @@
// small register queue used between the stages and at the output
// depends on nothing but its parameters
module chm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end
endmodule

@@ design/chm_front.sv @@
// front stage: takes transactions, masks the key, hashes it and reduces to a bucket
// depends on chm_pkg
module chm_front #(
  parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   operation_i,
  input  logic [chm_pkg::KEY_LOW_W-1:0]  key_low_i,
  input  logic [chm_pkg::KEY_HIGH_W-1:0] key_high_i,
  input  logic [chm_pkg::LEN_W-1:0]    key_length_i,
  input  logic [chm_pkg::VAL_W-1:0]    value_in_i,
  input  logic [chm_pkg::CFG_W-1:0]    bucket_count_i,
  output logic                         req_valid_o,
  output chm_pkg::req_t                req_o,
  input  logic                         req_ready_i
);
  import chm_pkg::*;

  localparam int RW = $clog2(BUCKETS + 1) + 1;

  typedef enum logic [8:0] {
    F_IDLE = 9'b000000001,
    F_K1   = 9'b000000010,
    F_K2   = 9'b000000100,
    F_H    = 9'b000001000,
    F_TAIL = 9'b000010000,
    F_FIN1 = 9'b000100000,
    F_FIN2 = 9'b001000000,
    F_MOD  = 9'b010000000,
    F_PUSH = 9'b100000000
  } fstate_e;

  fstate_e state_q, state_d;
  req_t item_q, item_d;
  logic [31:0] h_q, h_d, k_q, k_d;
  logic [1:0] pos_q, pos_d;
  logic [LEN_W-1:0] rest_q, rest_d;
  logic [4:0] bit_q, bit_d;
  logic [RW-1:0] rem_q, rem_d, div_q, div_d, rem_try;
  logic [31:0] div32, word, mul_a, mul_p, k_mix;
  logic [KEY_W-1:0] raw_key, masked_key;
  logic [127:0] key_ext;

  assign raw_key = {key_high_i, key_low_i};

  always_comb begin
    masked_key = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < key_length_i) begin
        masked_key[b*8 +: 8] = raw_key[b*8 +: 8];
      end
    end
  end

  // divisor clamp: zero acts as one, above the bucket store as its size
  always_comb begin
    div32 = 32'(bucket_count_i);
    if (div32 == 32'd0) begin
      div32 = 32'd1;
    end else if (div32 > 32'(BUCKETS)) begin
      div32 = 32'(BUCKETS);
    end
  end

  // key padded to four whole words so the last tail word reads zeros
  assign key_ext = {8'h00, item_q.key};
  assign word    = key_ext[{pos_q, 5'd0} +: 32];
  assign k_mix   = k_q ^ (k_q >> SH_K);
  assign rem_try = {rem_q[RW-2:0], h_q[31]};

  // the one shared multiplier
  always_comb begin
    case (state_q)
      F_K1:    mul_a = word;
      F_K2:    mul_a = k_mix;
      F_H:     mul_a = h_q;
      F_TAIL:  mul_a = h_q ^ word;
      F_FIN1:  mul_a = h_q ^ (h_q >> SH_A);
      default: mul_a = h_q;
    endcase
  end
  assign mul_p = mul_a * HASH_MUL;

  assign full        = (state_q != F_IDLE);
  assign req_valid_o = (state_q == F_PUSH);

  always_comb begin
    req_o        = item_q;
    req_o.bucket = MAX_BKT_W'(rem_q);
  end

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    h_d     = h_q;
    k_d     = k_q;
    pos_d   = pos_q;
    rest_d  = rest_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    div_d   = div_q;
    case (state_q)
      F_IDLE: begin
        if (push) begin
          item_d.op     = op_e'(operation_i);
          item_d.key    = masked_key;
          item_d.len    = key_length_i;
          item_d.value  = value_in_i;
          item_d.bucket = '0;
          h_d    = HASH_SEED ^ 32'(key_length_i);
          pos_d  = '0;
          rest_d = key_length_i;
          rem_d  = '0;
          div_d  = div32[RW-1:0];
          state_d = (op_e'(operation_i) == OP_CLEAN) ? F_PUSH : F_K1;
        end
      end
      F_K1: begin
        if (rest_q >= LEN_W'(4)) begin
          k_d = mul_p;
          state_d = F_K2;
        end else begin
          state_d = F_TAIL;
        end
      end
      F_K2: begin
        k_d = mul_p;
        state_d = F_H;
      end
      F_H: begin
        h_d    = mul_p ^ k_q;
        pos_d  = pos_q + 2'd1;
        rest_d = rest_q - LEN_W'(4);
        state_d = F_K1;
      end
      F_TAIL: begin
        // bytes past the length are already zero
        h_d = (rest_q != '0) ? mul_p : h_q;
        state_d = F_FIN1;
      end
      F_FIN1: begin
        h_d = mul_p;
        state_d = F_FIN2;
      end
      F_FIN2: begin
        h_d   = h_q ^ (h_q >> SH_B);
        bit_d = '0;
        rem_d = '0;
        state_d = F_MOD;
      end
      F_MOD: begin
        rem_d = (rem_try >= div_q) ? rem_try - div_q : rem_try;
        h_d   = h_q << 1;
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'd31) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (req_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    h_q    <= h_d;
    k_q    <= k_d;
    pos_q  <= pos_d;
    rest_q <= rest_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

@@ design/chm_back.sv @@
// back stage: walks the bucket chain and carries out get, set, delete and clean
// depends on chm_pkg
module chm_back #(
  parameter int ENTRIES = chm_pkg::ENTRIES_DEF,
  parameter int BUCKETS = chm_pkg::BUCKETS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  chm_pkg::req_t req_i,
  output logic          req_pop_o,
  input  logic          res_ready_i,
  output logic          res_push_o,
  output chm_pkg::res_t res_o
);
  import chm_pkg::*;

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NW = $clog2(ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [NW-1:0] NONE = NW'(ENTRIES);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_HEAD  = 5'b00010,
    B_CMP   = 5'b00100,
    B_FIN   = 5'b01000,
    B_CLEAN = 5'b10000
  } bstate_e;

  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [LEN_W-1:0] len_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [NW-1:0]    nxt_mem [ENTRIES];
  logic [NW-1:0]    head_mem [BUCKETS];

  logic [KEY_W-1:0] key_rd_q;
  logic [LEN_W-1:0] len_rd_q;
  logic [VAL_W-1:0] val_rd_q;
  logic [NW-1:0]    nxt_rd_q, head_rd_q;

  bstate_e state_q;
  req_t item_q;
  logic [ENTRIES-1:0] used_q;
  logic [BUCKETS-1:0] hvalid_q;
  logic [NW-1:0] cur_q, prev_q, steps_q, head_q, slot_q, snext_q, cnt_q, cidx_q;
  logic [VAL_W-1:0] sval_q;
  logic found_q;

  logic [BW-1:0] bkt;
  logic [EW-1:0] ent_ra;
  logic [NW-1:0] head_eff, cnt_n;
  logic match, clean_last, start;
  logic [EW-1:0] free_idx;
  logic free_ok;

  assign bkt = (state_q == B_IDLE) ? req_i.bucket[BW-1:0] : item_q.bucket[BW-1:0];
  assign head_eff = hvalid_q[bkt] ? head_rd_q : NONE;
  assign ent_ra = (state_q == B_HEAD) ? head_eff[EW-1:0] : nxt_rd_q[EW-1:0];
  assign match = used_q[cur_q[EW-1:0]] && (len_rd_q == item_q.len) && (key_rd_q == item_q.key);
  assign start = (state_q == B_IDLE) && req_valid_i && res_ready_i;
  assign req_pop_o = start;
  assign clean_last = (cidx_q == NW'(ENTRIES - 1));
  assign cnt_n = cnt_q + NW'(used_q[cidx_q[EW-1:0]]);

  // lowest free pool slot
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = EW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  always_comb begin
    res_push_o     = 1'b0;
    res_o.status   = ST_OK;
    res_o.value    = '0;
    res_o.cleared  = '0;
    if (state_q == B_CLEAN && clean_last) begin
      res_push_o    = 1'b1;
      res_o.cleared = CNT_W'(cnt_n);
    end else if (state_q == B_FIN) begin
      res_push_o = 1'b1;
      case (item_q.op)
        OP_GET, OP_DEL: begin
          if (found_q) begin
            res_o.value = sval_q;
          end else begin
            res_o.status = ST_NOT_FOUND;
          end
        end
        OP_SET: begin
          if (found_q) begin
            res_o.status = ST_PRESENT;
          end else if (!free_ok) begin
            res_o.status = ST_FULL;
          end
        end
        default: res_o.status = ST_OK;
      endcase
    end
  end

  logic set_new, del_hit;
  assign set_new = (state_q == B_FIN) && (item_q.op == OP_SET) && !found_q && free_ok;
  assign del_hit = (state_q == B_FIN) && (item_q.op == OP_DEL) && found_q;

  // pool and head stores
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[ent_ra];
    len_rd_q  <= len_mem[ent_ra];
    val_rd_q  <= val_mem[ent_ra];
    nxt_rd_q  <= nxt_mem[ent_ra];
    head_rd_q <= head_mem[bkt];
    if (set_new) begin
      key_mem[free_idx]  <= item_q.key;
      len_mem[free_idx]  <= item_q.len;
      val_mem[free_idx]  <= item_q.value;
      nxt_mem[free_idx]  <= head_q;
      head_mem[bkt]      <= NW'(free_idx);
    end else if (del_hit) begin
      if (prev_q < NONE) begin
        nxt_mem[prev_q[EW-1:0]] <= snext_q;
      end else begin
        head_mem[bkt] <= snext_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        item_q <= req_i;
        cidx_q <= '0;
        cnt_q  <= '0;
      end
      B_HEAD: begin
        head_q  <= head_eff;
        cur_q   <= head_eff;
        prev_q  <= NONE;
        steps_q <= '0;
        found_q <= 1'b0;
      end
      B_CMP: begin
        if (match) begin
          found_q <= 1'b1;
          slot_q  <= cur_q;
          snext_q <= nxt_rd_q;
          sval_q  <= val_rd_q;
        end else begin
          prev_q  <= cur_q;
          cur_q   <= nxt_rd_q;
          steps_q <= steps_q + 1'b1;
        end
      end
      B_CLEAN: begin
        cidx_q <= cidx_q + 1'b1;
        cnt_q  <= cnt_n;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      used_q   <= '0;
      hvalid_q <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (start) begin
            state_q <= (req_i.op == OP_CLEAN) ? B_CLEAN : B_HEAD;
          end
        end
        B_HEAD: begin
          state_q <= (head_eff >= NONE) ? B_FIN : B_CMP;
        end
        B_CMP: begin
          if (match || nxt_rd_q >= NONE || steps_q == NW'(ENTRIES - 1)) begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (set_new) begin
            used_q[free_idx] <= 1'b1;
            hvalid_q[bkt]    <= 1'b1;
          end else if (del_hit) begin
            used_q[slot_q[EW-1:0]] <= 1'b0;
            if (!(prev_q < NONE)) begin
              hvalid_q[bkt] <= 1'b1;
            end
          end
          state_q <= B_IDLE;
        end
        B_CLEAN: begin
          used_q[cidx_q[EW-1:0]] <= 1'b0;
          if (clean_last) begin
            hvalid_q <= '0;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

@@ design/chm_checker.sv @@
// port-level checks of the chained hash map, bound to the top level
// depends on chm_pkg and chained_hash_map_string_keys
module chm_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic [1:0]                     status_o,
  input logic [chm_pkg::VAL_W-1:0]      value_out_o,
  input logic [chm_pkg::CNT_W-1:0]      cleared_count_o
);
  import chm_pkg::*;

  // a taken transaction makes the front busy, so full is high after the take
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full) else $error("front took a transaction but is not busy");

  // nothing waits on the result side right after reset
  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty) else $error("result present straight after reset");

  // a clean count only comes with ok status and no handle
  a_clean_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && cleared_count_o != '0 |-> status_o == ST_OK && value_out_o == '0)
    else $error("clean result carries other fields");

  // a failed transaction carries no handle and no clean count
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (status_o == ST_NOT_FOUND || status_o == ST_PRESENT || status_o == ST_FULL)
    |-> value_out_o == '0 && cleared_count_o == '0)
    else $error("failed transaction carries a handle");
endmodule

bind chained_hash_map_string_keys chm_port_checker u_chm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .status_o        (status_o),
  .value_out_o     (value_out_o),
  .cleared_count_o (cleared_count_o)
);

@@ bench/chm_checker.sv @@
// checker for the chained hash map: watches both queue sides, keeps its own
// copy of the table and compares every result; depends on chm_pkg
`timescale 1ns / 100ps
module chm_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic [1:0]                     operation_i,
  input  logic [chm_pkg::KEY_LOW_W-1:0]  key_low_i,
  input  logic [chm_pkg::KEY_HIGH_W-1:0] key_high_i,
  input  logic [chm_pkg::LEN_W-1:0]      key_length_i,
  input  logic [chm_pkg::VAL_W-1:0]      value_in_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [1:0]                     status_o,
  input  logic [chm_pkg::VAL_W-1:0]      value_out_o,
  input  logic [chm_pkg::CNT_W-1:0]      cleared_count_o,
  input  logic                           cfg_we_i,
  input  logic [chm_pkg::CFG_W-1:0]      cfg_wdata_i,
  output int                             fail_count,
  output int                             pending_count,
  output int                             result_count
);
  import chm_pkg::*;

  localparam int SLOTS = 64;
  localparam int NO_SLOT = SLOTS;

  logic [63:0]      slot_lo [SLOTS];
  logic [55:0]      slot_hi [SLOTS];
  logic [3:0]       slot_len [SLOTS];
  logic [63:0]      slot_val [SLOTS];
  int               slot_next [SLOTS];
  bit               slot_busy [SLOTS];
  int               head_of [SLOTS];
  logic [CFG_W-1:0] divisor_reg;
  res_t             expected_q[$];

  function automatic logic [31:0] murmur_of(logic [63:0] lo, logic [55:0] hi,
                                            int len);
    logic [7:0]  b [16];
    logic [31:0] h, k;
    int p;
    for (int i = 0; i < 8; i++) begin
      b[i] = lo[8*i +: 8];
      b[i+8] = (i < 7) ? hi[8*i +: 8] : 8'h00;
    end
    h = HASH_SEED ^ len;
    p = 0;
    while (len - p >= 4) begin
      k = {b[p+3], b[p+2], b[p+1], b[p]};
      k = k * HASH_MUL;
      k = k ^ (k >> SH_K);
      k = k * HASH_MUL;
      h = h * HASH_MUL;
      h = h ^ k;
      p += 4;
    end
    if (len - p == 3) h = h ^ (32'(b[p+2]) << 16);
    if (len - p >= 2) h = h ^ (32'(b[p+1]) << 8);
    if (len - p >= 1) begin
      h = h ^ 32'(b[p]);
      h = h * HASH_MUL;
    end
    h = h ^ (h >> SH_A);
    h = h * HASH_MUL;
    h = h ^ (h >> SH_B);
    return h;
  endfunction

  // apply one transaction to the shadow table and return its result
  function automatic res_t map_apply(op_e op, logic [63:0] lo_in, logic [55:0] hi_in,
                                     logic [3:0] len_in, logic [63:0] val);
    res_t r;
    int len, bkt, div, cur, prev, hit, steps, n;
    logic [63:0] lo;
    logic [55:0] hi;
    r = '{status: ST_OK, value: '0, cleared: '0};
    len = (len_in > 15) ? 15 : int'(len_in);
    lo = '0;
    hi = '0;
    for (int i = 0; i < 8; i++) if (i < len) lo[8*i +: 8] = lo_in[8*i +: 8];
    for (int i = 0; i < 7; i++) if (i + 8 < len) hi[8*i +: 8] = hi_in[8*i +: 8];
    if (op == OP_CLEAN) begin
      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i]) n++;
        slot_busy[i] = 0;
        head_of[i] = NO_SLOT;
      end
      r.cleared = CNT_W'(n);
      return r;
    end
    div = (divisor_reg == 0) ? 1 : (divisor_reg > SLOTS) ? SLOTS : int'(divisor_reg);
    bkt = int'(murmur_of(lo, hi, len) % div);
    cur = head_of[bkt];
    prev = NO_SLOT;
    hit = NO_SLOT;
    steps = 0;
    while (cur < SLOTS && steps < SLOTS && hit == NO_SLOT) begin
      if (slot_busy[cur] && slot_len[cur] == len && slot_lo[cur] == lo && slot_hi[cur] == hi)
        hit = cur;
      else begin
        prev = cur;
        cur = slot_next[cur];
        steps++;
      end
    end
    case (op)
      OP_GET: begin
        if (hit < SLOTS) r.value = slot_val[hit];
        else r.status = ST_NOT_FOUND;
      end
      OP_DEL: begin
        if (hit < SLOTS) begin
          r.value = slot_val[hit];
          if (prev < SLOTS) slot_next[prev] = slot_next[hit];
          else head_of[bkt] = slot_next[hit];
          slot_busy[hit] = 0;
        end else r.status = ST_NOT_FOUND;
      end
      default: begin
        if (hit < SLOTS) r.status = ST_PRESENT;
        else begin
          n = 0;
          while (n < SLOTS && slot_busy[n]) n++;
          if (n >= SLOTS) r.status = ST_FULL;
          else begin
            slot_lo[n] = lo;
            slot_hi[n] = hi;
            slot_len[n] = 4'(len);
            slot_val[n] = val;
            slot_next[n] = head_of[bkt];
            slot_busy[n] = 1;
            head_of[bkt] = n;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
    divisor_reg = CFG_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 0;
      head_of[i] = NO_SLOT;
      slot_next[i] = 0;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (!empty && pop) begin
        result_count++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(status_o), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (status_o != want.status)
            report_mismatch("status", 64'(status_o), 64'(want.status));
          if (value_out_o != want.value) report_mismatch("value", value_out_o, want.value);
          if (cleared_count_o != want.cleared)
            report_mismatch("cleared", 64'(cleared_count_o), 64'(want.cleared));
        end
      end
      if (push && !full)
        expected_q.push_back(map_apply(op_e'(operation_i), key_low_i, key_high_i,
                                       key_length_i, value_in_i));
      if (cfg_we_i) divisor_reg = cfg_wdata_i;
      pending_count = expected_q.size();
    end
  end
endmodule

@@ bench/tb_top.sv @@
// testbench top of the chained hash map: clock, reset, stimulus and verdict;
// depends on chm_pkg, chained_hash_map_string_keys and chm_checker
`timescale 1ns / 100ps
module tb_top;
  import chm_pkg::*;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  push = 0;
  logic                  full;
  logic [1:0]            operation_i = OP_GET;
  logic [KEY_LOW_W-1:0]  key_low_i = '0;
  logic [KEY_HIGH_W-1:0] key_high_i = '0;
  logic [LEN_W-1:0]      key_length_i = '0;
  logic [VAL_W-1:0]      value_in_i = '0;
  logic                  empty;
  logic                  pop = 0;
  logic [1:0]            status_o;
  logic [VAL_W-1:0]      value_out_o;
  logic [CNT_W-1:0]      cleared_count_o;
  logic                  cfg_we_i = 0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  int fail_count, pending_count, result_count;

  // idling control: idle_off for both sides, hold_pop for the result side
  bit idle_off = 0;
  bit hold_pop = 0;

  // small key pool so that sets, hits, conflicts and deletes meet often
  logic [63:0] pool_lo [16];
  logic [55:0] pool_hi [16];
  logic [3:0]  pool_len [16];
  int sets_seen = 0, cleans_seen = 0;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  chained_hash_map_string_keys u_top (
    .clk_i, .rst_ni, .push, .full, .operation_i, .key_low_i, .key_high_i,
    .key_length_i, .value_in_i, .empty, .pop, .status_o, .value_out_o,
    .cleared_count_o, .cfg_we_i, .cfg_wdata_i
  );

  chm_checker u_checker (.*);

  // one transaction onto the input side; random idle bursts before it
  // push stays high between back-to-back transactions
  task automatic send_item(op_e op, logic [63:0] lo, logic [55:0] hi,
                           logic [3:0] len, logic [63:0] val);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    operation_i <= op;
    key_low_i <= lo;
    key_high_i <= hi;
    key_length_i <= len;
    value_in_i <= val;
    push <= 1;
    do @(posedge clk_i); while (full);
    if (op == OP_SET) sets_seen++;
    if (op == OP_CLEAN) cleans_seen++;
  endtask

  task automatic send_pooled();
    int k, r;
    k = $urandom_range(0, 15);
    r = $urandom_range(0, 99);
    if (r < 40) send_item(OP_SET, pool_lo[k], pool_hi[k], pool_len[k], {$urandom, $urandom});
    else if (r < 70) send_item(OP_GET, pool_lo[k], pool_hi[k], pool_len[k], {$urandom, $urandom});
    else if (r < 93) send_item(OP_DEL, pool_lo[k], pool_hi[k], pool_len[k], {$urandom, $urandom});
    else if (r < 95) send_item(OP_CLEAN, {$urandom, $urandom}, 56'({$urandom, $urandom}),
                               4'($urandom), {$urandom, $urandom});
    else
      // noise: a fresh random key, unused bytes random too
      send_item(op_e'($urandom_range(0, 2)), {$urandom, $urandom}, 56'({$urandom, $urandom}),
                4'($urandom), {$urandom, $urandom});
  endtask

  // stops offering, waits until the block has drained, then a margin for a clean sweep
  task automatic drain();
    push <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_divisor(logic [CFG_W-1:0] d);
    cfg_wdata_i <= d;
    cfg_we_i <= 1;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // result side: random pop with idle bursts, and a held stall on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_pop || (!idle_off && $urandom_range(0, 3) == 0)) begin
        pop <= 0;
        if (!hold_pop) repeat ($urandom_range(1, 4)) @(posedge clk_i);
        else @(posedge clk_i);
      end else begin
        pop <= 1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      pool_lo[i] = {$urandom, $urandom};
      pool_hi[i] = 56'({$urandom, $urandom});
      pool_len[i] = 4'(i);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes of fields, every operation, the special cases
    send_item(OP_GET, '0, '0, 4'd0, '0);                 // absent empty key
    send_item(OP_SET, '0, '0, 4'd0, '1);                 // empty key is valid
    send_item(OP_SET, '1, '0, 4'd0, '0);                 // same empty key, bytes ignored
    send_item(OP_GET, '1, '1, 4'd0, '0);
    send_item(OP_SET, '1, '1, 4'd15, 64'h0123_4567_89ab_cdef);
    send_item(OP_SET, '1, '1, 4'd15, '0);                // conflict keeps old value
    send_item(OP_GET, '1, '1, 4'd15, '0);
    send_item(OP_SET, '1, '1, 4'd8, 64'h55);
    send_item(OP_SET, '1, '1, 4'd9, 64'haa);
    send_item(OP_DEL, '1, '1, 4'd8, '0);
    send_item(OP_DEL, '1, '1, 4'd8, '0);                 // absent delete
    send_item(OP_GET, '1, '1, 4'd9, '0);
    send_item(OP_CLEAN, '1, '1, 4'd15, '1);
    send_item(OP_CLEAN, '0, '0, 4'd0, '0);               // clean of an empty map
    drain();
    set_divisor(7'd1);                                   // single chain
    for (int i = 0; i < 66; i++)                         // fills the pool, then full
      send_item(OP_SET, 64'(i), 56'(i), 4'd8, 64'(i));
    send_item(OP_DEL, 64'd30, '0, 4'd8, '0);             // delete from mid chain
    send_item(OP_GET, 64'd31, '0, 4'd8, '0);
    drain();
    set_divisor(7'd64);                                  // stranded entries
    send_item(OP_GET, 64'd5, '0, 4'd8, '0);
    send_item(OP_CLEAN, '0, '0, 4'd0, '0);

    // random phases, different bucket counts including out of range
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_divisor(7'd0);
        1: set_divisor(7'd127);
        2: set_divisor(7'd3);
        3: set_divisor(7'd64);
        4: set_divisor(7'($urandom_range(1, 64)));
        default: set_divisor(7'($urandom));
      endcase
      if (ph == 2) begin
        // long receiver stall while the sender keeps offering
        fork
          begin
            hold_pop = 1;
            repeat (600) @(posedge clk_i);
            hold_pop = 0;
          end
          repeat (20) send_pooled();
        join
      end
      if (ph == 5) idle_off = 1;
      repeat (130) send_pooled();
    end
    drain();
    $display("run covered %0d sets, %0d cleans and %0d checked results over six bucket counts",
             sets_seen, cleans_seen, result_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ filelist.f @@
design/chm_pkg.sv
design/chm_fifo.sv
design/chm_front.sv
design/chm_back.sv
design/chained_hash_map_string_keys.sv
design/chm_checker.sv
bench/chm_checker.sv
bench/tb_top.sv
